[rtl/cel_pkg.sv]
// cel_pkg: shared types, character codes and classification functions
// for the condition expression lexer; no dependencies
package cel_pkg;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_OPERAND = 3'd1,
    MODE_REL     = 3'd2,
    MODE_LOGIC   = 3'd3,
    MODE_OPEN    = 3'd4,
    MODE_CLOSE   = 3'd5,
    MODE_BANG    = 3'd6,
    MODE_BAD     = 3'd7
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic        bang;
    logic [15:0] op_buf;
    logic [1:0]  op_len;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{mode: MODE_START, bang: 1'b0,
                                       op_buf: 16'h0000, op_len: 2'd0};

  localparam logic [15:0] CH_GT   = 16'h003E;
  localparam logic [15:0] CH_LT   = 16'h003C;
  localparam logic [15:0] CH_EQ   = 16'h003D;
  localparam logic [15:0] CH_BANG = 16'h0021;
  localparam logic [15:0] CH_AMP  = 16'h0026;
  localparam logic [15:0] CH_BAR  = 16'h007C;
  localparam logic [15:0] CH_LPAR = 16'h0028;
  localparam logic [15:0] CH_RPAR = 16'h0029;

  // two-character operators, first character in the low byte
  localparam logic [15:0] OP_GE  = {CH_EQ[7:0],   CH_GT[7:0]};
  localparam logic [15:0] OP_EQ  = {CH_EQ[7:0],   CH_EQ[7:0]};
  localparam logic [15:0] OP_NE  = {CH_EQ[7:0],   CH_BANG[7:0]};
  localparam logic [15:0] OP_LE  = {CH_EQ[7:0],   CH_LT[7:0]};
  localparam logic [15:0] OP_AND = {CH_AMP[7:0],  CH_AMP[7:0]};
  localparam logic [15:0] OP_OR  = {CH_BAR[7:0],  CH_BAR[7:0]};

  localparam logic [1:0] LEN_ONE = 2'd1;
  localparam logic [1:0] LEN_TWO = 2'd2;

  function automatic logic is_space(input logic [15:0] c);
    return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
           c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
           c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
           c == 16'h3000;
  endfunction

  function automatic logic is_rel_char(input logic [15:0] c);
    return c == CH_GT || c == CH_EQ || c == CH_LT;
  endfunction

  function automatic logic is_rel_op(input logic [15:0] buf_v, input logic [1:0] len);
    return (len == LEN_ONE && (buf_v == CH_GT || buf_v == CH_LT)) ||
           (len == LEN_TWO && (buf_v == OP_GE || buf_v == OP_EQ ||
                               buf_v == OP_LE || buf_v == OP_NE));
  endfunction

  function automatic logic is_log_op(input logic [15:0] buf_v, input logic [1:0] len);
    return (len == LEN_ONE && buf_v == CH_BANG) ||
           (len == LEN_TWO && (buf_v == OP_AND || buf_v == OP_OR));
  endfunction

endpackage

[rtl/cel_lex_step.sv]
// cel_lex_step: one-character lexer transition, purely combinational
// depends on cel_pkg
module cel_lex_step import cel_pkg::*; (
  input  lex_state_t  st,
  input  logic [15:0] c,
  output lex_state_t  nxt,
  output logic        kept,
  output logic        start
);

  logic        proc;
  logic        opok;
  logic        rel;
  logic        amp_bar;
  logic [15:0] pair;
  logic        begin_tok;
  logic        ext;
  mode_t       tok_mode;

  assign proc    = !is_space(c) && st.mode != MODE_BAD;
  assign opok    = is_rel_op(st.op_buf, st.op_len) || is_log_op(st.op_buf, st.op_len);
  assign rel     = is_rel_char(c);
  assign amp_bar = (c == CH_AMP) || (c == CH_BAR);
  assign pair    = {st.op_buf[15:8] | c[7:0], st.op_buf[7:0]};

  always_comb begin : next_state
    nxt       = st;
    begin_tok = 1'b0;
    ext       = 1'b0;
    tok_mode  = MODE_OPERAND;
    if (proc) begin
      unique case (st.mode)
        MODE_START, MODE_OPEN: begin
          if (rel || amp_bar || c == CH_RPAR) nxt.mode = MODE_BAD;
          else if (c == CH_BANG) begin begin_tok = 1'b1; tok_mode = MODE_BANG; end
          else if (c == CH_LPAR) begin begin_tok = 1'b1; tok_mode = MODE_OPEN; end
          else begin begin_tok = 1'b1; tok_mode = MODE_OPERAND; end
        end
        MODE_OPERAND: begin
          if (rel) begin begin_tok = 1'b1; tok_mode = MODE_REL; end
          else if (c == CH_BANG || amp_bar) begin
            begin_tok = 1'b1;
            tok_mode  = MODE_LOGIC;
          end
          else if (c == CH_LPAR) nxt.mode = MODE_BAD;
          else if (c == CH_RPAR) begin begin_tok = 1'b1; tok_mode = MODE_CLOSE; end
          else begin
            nxt.op_len = 2'd0;
            nxt.op_buf = 16'h0000;
          end
        end
        MODE_REL: begin
          if (rel || c == CH_BANG) begin
            if (st.op_len == LEN_ONE && is_rel_op(pair, LEN_TWO)) ext = 1'b1;
            else if (c == CH_BANG) begin begin_tok = 1'b1; tok_mode = MODE_BANG; end
            else nxt.mode = MODE_BAD;
          end
          else if (c == CH_LPAR) begin
            if (opok) begin begin_tok = 1'b1; tok_mode = MODE_OPEN; end
            else nxt.mode = MODE_BAD;
          end
          else if (c == CH_RPAR || amp_bar) nxt.mode = MODE_BAD;
          else if (opok) begin begin_tok = 1'b1; tok_mode = MODE_OPERAND; end
          else nxt.mode = MODE_BAD;
        end
        MODE_LOGIC: begin
          if (rel) begin
            if (c == CH_EQ && st.op_len == LEN_ONE && st.op_buf == CH_BANG) ext = 1'b1;
            else nxt.mode = MODE_BAD;
          end
          else if (c == CH_LPAR) begin
            if (opok) begin begin_tok = 1'b1; tok_mode = MODE_OPEN; end
            else nxt.mode = MODE_BAD;
          end
          else if (amp_bar || c == CH_BANG) begin
            if (st.op_len == LEN_ONE && is_log_op(pair, LEN_TWO)) ext = 1'b1;
            else if (c == CH_BANG && is_log_op(st.op_buf, st.op_len)) begin
              begin_tok = 1'b1;
              tok_mode  = MODE_BANG;
            end
            else nxt.mode = MODE_BAD;
          end
          else if (c == CH_RPAR) nxt.mode = MODE_BAD;
          else if (opok) begin begin_tok = 1'b1; tok_mode = MODE_OPERAND; end
          else nxt.mode = MODE_BAD;
        end
        MODE_CLOSE: begin
          if (rel) begin begin_tok = 1'b1; tok_mode = MODE_REL; end
          else if (amp_bar) begin begin_tok = 1'b1; tok_mode = MODE_LOGIC; end
          else if (c == CH_RPAR) begin begin_tok = 1'b1; tok_mode = MODE_CLOSE; end
          else nxt.mode = MODE_BAD;
        end
        MODE_BANG: begin
          if (rel || amp_bar || c == CH_RPAR) nxt.mode = MODE_BAD;
          else if (c == CH_LPAR) begin begin_tok = 1'b1; tok_mode = MODE_OPEN; end
          else begin begin_tok = 1'b1; tok_mode = MODE_OPERAND; end
        end
        MODE_BAD: nxt.mode = MODE_BAD;
      endcase
      if (begin_tok) begin
        nxt.op_buf = {8'h00, c[7:0]};
        nxt.op_len = LEN_ONE;
        nxt.mode   = tok_mode;
      end
      if (ext) begin
        nxt.op_buf = pair;
        nxt.op_len = LEN_TWO;
      end
      nxt.bang = (nxt.mode == MODE_BANG);
    end
  end

  always_comb begin : step_outputs
    kept  = proc && nxt.mode != MODE_BAD;
    start = begin_tok;
  end

endmodule

[rtl/condition_expression_lexer_core.sv]
// condition_expression_lexer_core: whitespace-dropping condition text lexer
// depends on cel_pkg and cel_lex_step
// a character is held in the input register, then its result in the output register
// throughput: one character per cycle while no result is stalled by out_ready
// reset: rst_n synchronous active low clears both stages and the lexer state;
// the lexer state also returns to reset after every last character
module condition_expression_lexer_core import cel_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_out_char,
  output logic        out_char_present,
  output logic        out_token_start,
  output logic        out_end_of_text,
  output logic        out_text_valid
);

  logic        in_v_r;
  logic        in_v_nxt;
  logic [15:0] in_char_r;
  logic        in_last_r;
  lex_state_t  state_r;
  lex_state_t  state_nxt;
  lex_state_t  step_st;
  logic        kept;
  logic        start;
  logic        fire;
  logic        emit;
  logic        out_v_r;
  logic        out_v_nxt;
  logic [15:0] out_char_r;
  logic        out_present_r;
  logic        out_start_r;
  logic        out_eot_r;
  logic        out_tv_r;

  cel_lex_step u_step (
    .st    (state_r),
    .c     (in_char_r),
    .nxt   (step_st),
    .kept  (kept),
    .start (start)
  );

  assign fire     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || fire;
  assign emit     = kept || in_last_r;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_valid && in_ready) in_v_nxt = 1'b1;
    else if (fire)            in_v_nxt = 1'b0;

    out_v_nxt = out_v_r && !out_ready;
    if (fire && emit) out_v_nxt = 1'b1;

    state_nxt = state_r;
    if (fire) state_nxt = in_last_r ? LEX_RESET : step_st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= LEX_RESET;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_code;
      in_last_r <= in_last_char;
    end
    if (fire && emit) begin
      out_char_r    <= kept ? in_char_r : 16'h0000;
      out_present_r <= kept;
      out_start_r   <= kept && start;
      out_eot_r     <= in_last_r;
      out_tv_r      <= in_last_r &&
                       (step_st.mode == MODE_OPERAND || step_st.mode == MODE_CLOSE);
    end
  end

  assign out_valid        = out_v_r;
  assign out_out_char     = out_char_r;
  assign out_char_present = out_present_r;
  assign out_token_start  = out_start_r;
  assign out_end_of_text  = out_eot_r;
  assign out_text_valid   = out_tv_r;

endmodule

[rtl/cel_checker.sv]
// cel_checker: port-level checks on the condition expression lexer
// bound to condition_expression_lexer_core; no other dependencies
module cel_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] in_char_code,
  input logic        in_last_char,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_out_char,
  input logic        out_char_present,
  input logic        out_token_start,
  input logic        out_end_of_text,
  input logic        out_text_valid
);

  // stalled result transfer holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out_char) &&
      $stable(out_char_present) && $stable(out_end_of_text) && $stable(out_text_valid))
    else $error("stalled result changed");

  // verdict-only result appears only at end of text
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_present |-> out_end_of_text)
    else $error("empty result before end of text");

  // verdict only on the last result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_text |-> !out_text_valid)
    else $error("text_valid outside end of text");

  // verdict-only result carries no character and no token mark
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_present |-> !out_token_start && out_out_char == 16'h0000)
    else $error("verdict-only result carries a character");

endmodule

bind condition_expression_lexer_core cel_checker u_cel_checker (.*);

[sim/condition_expression_lexer_core_tb.sv]
// condition_expression_lexer_core_tb: self-checking bench for the condition text lexer
// predicts every result from its own copy of the lexer modes and checks each transfer
// depends on cel_pkg and condition_expression_lexer_core
`timescale 1ns / 100ps

module condition_expression_lexer_core_tb import cel_pkg::*;;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [15:0] ch;
    logic        present;
    logic        tok_start;
    logic        eot;
    logic        text_ok;
  } lex_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_char_code = 16'h0000;
  logic        in_last_char = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_out_char;
  logic        out_char_present;
  logic        out_token_start;
  logic        out_end_of_text;
  logic        out_text_valid;

  int send_idle_pct = 17;
  int recv_idle_pct = 72;
  int fail_count = 0;
  int cycle_count = 0;

  lex_out_t    expected_chars[$];
  logic [15:0] text_q[$];

  mode_t       lex_mode = MODE_START;
  logic        bang_pending = 1'b0;
  logic [15:0] op_buf = 16'h0000;
  logic [1:0]  op_len = 2'd0;

  condition_expression_lexer_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_out_char     (out_out_char),
    .out_char_present (out_char_present),
    .out_token_start  (out_token_start),
    .out_end_of_text  (out_end_of_text),
    .out_text_valid   (out_text_valid)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- lexer predictor

  function automatic logic blank_code(input logic [15:0] c);
    if (c == 16'h0020 || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680) return 1'b1;
    if (c >= 16'h0009 && c <= 16'h000D) return 1'b1;
    if (c >= 16'h2000 && c <= 16'h200A) return 1'b1;
    return c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
           c == 16'h3000;
  endfunction

  function automatic logic rel_char(input logic [15:0] c);
    return c == CH_GT || c == CH_EQ || c == CH_LT;
  endfunction

  function automatic logic rel_complete(input logic [15:0] b, input logic [1:0] n);
    if (n == LEN_ONE) return b == CH_GT || b == CH_LT;
    if (n == LEN_TWO) return b == OP_GE || b == OP_EQ || b == OP_LE || b == OP_NE;
    return 1'b0;
  endfunction

  function automatic logic logic_complete(input logic [15:0] b, input logic [1:0] n);
    if (n == LEN_ONE) return b == CH_BANG;
    if (n == LEN_TWO) return b == OP_AND || b == OP_OR;
    return 1'b0;
  endfunction

  function automatic logic open_token(input logic [15:0] c, input mode_t m);
    op_buf = {8'h00, c[7:0]};
    op_len = LEN_ONE;
    lex_mode = m;
    return 1'b1;
  endfunction

  function automatic void extend_token(input logic [15:0] c);
    op_buf = op_buf | {c[7:0], 8'h00};
    op_len = LEN_TWO;
  endfunction

  // one kept character through the mode machine; returns the token start flag
  function automatic logic lex_advance(input logic [15:0] c);
    logic        opok;
    logic        start;
    logic [15:0] pair;
    opok = rel_complete(op_buf, op_len) || logic_complete(op_buf, op_len);
    start = 1'b0;
    pair = {c[7:0], op_buf[7:0]};
    case (lex_mode)
      MODE_START: begin
        if (rel_char(c) || c == CH_AMP || c == CH_BAR || c == CH_RPAR) lex_mode = MODE_BAD;
        else if (c == CH_BANG) start = open_token(c, MODE_BANG);
        else if (c == CH_LPAR) start = open_token(c, MODE_OPEN);
        else start = open_token(c, MODE_OPERAND);
      end
      MODE_OPERAND: begin
        if (rel_char(c)) start = open_token(c, MODE_REL);
        else if (c == CH_BANG || c == CH_AMP || c == CH_BAR) start = open_token(c, MODE_LOGIC);
        else if (c == CH_LPAR) lex_mode = MODE_BAD;
        else if (c == CH_RPAR) start = open_token(c, MODE_CLOSE);
        else begin
          op_len = 2'd0;
          op_buf = 16'h0000;
        end
      end
      MODE_REL: begin
        if (rel_char(c) || c == CH_BANG) begin
          if (op_len == LEN_ONE && (pair == OP_GE || pair == OP_EQ || pair == OP_LE ||
                                    pair == OP_NE)) extend_token(c);
          else if (c == CH_BANG) start = open_token(c, MODE_BANG);
          else lex_mode = MODE_BAD;
        end else if (c == CH_LPAR) begin
          if (opok) start = open_token(c, MODE_OPEN);
          else lex_mode = MODE_BAD;
        end else if (c == CH_RPAR || c == CH_AMP || c == CH_BAR) begin
          lex_mode = MODE_BAD;
        end else begin
          if (opok) start = open_token(c, MODE_OPERAND);
          else lex_mode = MODE_BAD;
        end
      end
      MODE_LOGIC: begin
        if (rel_char(c)) begin
          if (c == CH_EQ && op_len == LEN_ONE && op_buf == CH_BANG) extend_token(c);
          else lex_mode = MODE_BAD;
        end else if (c == CH_LPAR) begin
          if (opok) start = open_token(c, MODE_OPEN);
          else lex_mode = MODE_BAD;
        end else if (c == CH_AMP || c == CH_BAR || c == CH_BANG) begin
          if (op_len == LEN_ONE && (pair == OP_AND || pair == OP_OR)) extend_token(c);
          else if (c == CH_BANG && logic_complete(op_buf, op_len))
            start = open_token(c, MODE_BANG);
          else lex_mode = MODE_BAD;
        end else if (c == CH_RPAR) begin
          lex_mode = MODE_BAD;
        end else begin
          if (opok) start = open_token(c, MODE_OPERAND);
          else lex_mode = MODE_BAD;
        end
      end
      MODE_OPEN: begin
        if (rel_char(c) || c == CH_RPAR || c == CH_AMP || c == CH_BAR) lex_mode = MODE_BAD;
        else if (c == CH_BANG) start = open_token(c, MODE_BANG);
        else if (c == CH_LPAR) start = open_token(c, MODE_OPEN);
        else start = open_token(c, MODE_OPERAND);
      end
      MODE_CLOSE: begin
        if (rel_char(c)) start = open_token(c, MODE_REL);
        else if (c == CH_AMP || c == CH_BAR) start = open_token(c, MODE_LOGIC);
        else if (c == CH_RPAR) start = open_token(c, MODE_CLOSE);
        else lex_mode = MODE_BAD;
      end
      MODE_BANG: begin
        if (rel_char(c) || c == CH_AMP || c == CH_BAR || c == CH_RPAR) lex_mode = MODE_BAD;
        else if (c == CH_LPAR) start = open_token(c, MODE_OPEN);
        else start = open_token(c, MODE_OPERAND);
      end
      default: lex_mode = MODE_BAD;
    endcase
    bang_pending = (lex_mode == MODE_BANG);
    return start;
  endfunction

  function automatic void lex_next_char(input logic [15:0] c, input logic last);
    lex_out_t r;
    logic     kept;
    logic     start;
    kept = 1'b0;
    start = 1'b0;
    if (!blank_code(c) && lex_mode != MODE_BAD) begin
      start = lex_advance(c);
      kept = (lex_mode != MODE_BAD);
    end
    if (kept || last) begin
      r.ch = kept ? c : 16'h0000;
      r.present = kept;
      r.tok_start = kept && start;
      r.eot = last;
      r.text_ok = last && (lex_mode == MODE_OPERAND || lex_mode == MODE_CLOSE);
      expected_chars.push_back(r);
    end
    if (last) begin
      lex_mode = MODE_START;
      bang_pending = 1'b0;
      op_buf = 16'h0000;
      op_len = 2'd0;
    end
  endfunction

  // ---------------------------------------------------------------- transfer monitor

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    lex_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) lex_next_char(in_char_code, in_last_char);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result transfer: out_char %0h", out_out_char);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          check_field("out_char", want.ch, out_out_char);
          check_field("char_present", {15'd0, want.present}, {15'd0, out_char_present});
          check_field("token_start", {15'd0, want.tok_start}, {15'd0, out_token_start});
          check_field("end_of_text", {15'd0, want.eot}, {15'd0, out_end_of_text});
          check_field("text_valid", {15'd0, want.text_ok}, {15'd0, out_text_valid});
        end
      end
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_char(input logic [15:0] c, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_char({8'h00, s[i]}, fin && i == s.len() - 1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_chars.size() != 0);
  endtask

  function automatic logic [15:0] pick_blank();
    logic [15:0] r;
    r = 16'($urandom_range(0, 24));
    if (r < 5) return 16'h0009 + r;
    if (r < 16) return 16'h2000 + r - 16'd5;
    case (r)
      16:      return 16'h0020;
      17:      return 16'h0085;
      18:      return 16'h00A0;
      19:      return 16'h1680;
      20:      return 16'h2028;
      21:      return 16'h2029;
      22:      return 16'h202F;
      23:      return 16'h205F;
      default: return 16'h3000;
    endcase
  endfunction

  function automatic logic [15:0] pick_noise();
    case ($urandom_range(0, 10))
      0:       return CH_GT;
      1:       return CH_LT;
      2:       return CH_EQ;
      3:       return CH_BANG;
      4:       return CH_AMP;
      5:       return CH_BAR;
      6:       return CH_LPAR;
      7:       return CH_RPAR;
      8:       return pick_blank();
      9:       return 16'h0061 + 16'($urandom_range(0, 25));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void put_char(input logic [15:0] c);
    if ($urandom_range(0, 9) == 0) text_q.push_back(pick_blank());
    text_q.push_back(c);
  endfunction

  function automatic void put_operand();
    logic [15:0] c;
    int          r;
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 35);
        c = (r < 26) ? 16'(16'h0061 + r) : 16'(16'h0030 + r - 26);
      end else begin
        c = 16'($urandom);
        while (blank_code(c) || rel_char(c) || c == CH_BANG || c == CH_AMP ||
               c == CH_BAR || c == CH_LPAR || c == CH_RPAR) c = 16'($urandom);
      end
      put_char(c);
    end
  endfunction

  function automatic void put_term(input int depth);
    if ($urandom_range(0, 3) == 0) put_char(CH_BANG);
    if (depth < 2 && $urandom_range(0, 3) == 0) begin
      put_char(CH_LPAR);
      put_expr(depth + 1);
      put_char(CH_RPAR);
    end else begin
      put_operand();
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 5))
          0: put_char(CH_GT);
          1: put_char(CH_LT);
          2: begin put_char(CH_GT); put_char(CH_EQ); end
          3: begin put_char(CH_EQ); put_char(CH_EQ); end
          4: begin put_char(CH_LT); put_char(CH_EQ); end
          default: begin put_char(CH_BANG); put_char(CH_EQ); end
        endcase
        put_operand();
      end
    end
  endfunction

  function automatic void put_expr(input int depth);
    repeat ($urandom_range(0, 2)) begin
      put_term(depth);
      if ($urandom_range(0, 1) == 1) begin put_char(CH_AMP); put_char(CH_AMP); end
      else begin put_char(CH_BAR); put_char(CH_BAR); end
    end
    put_term(depth);
  endfunction

  // mostly well-formed texts, some with one character broken, cut short or pure noise
  function automatic void build_text();
    int kind;
    int n;
    text_q.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 7) put_expr(0);
    else repeat ($urandom_range(1, 8)) text_q.push_back(pick_noise());
    if (kind == 6) text_q[$urandom_range(0, text_q.size() - 1)] = pick_noise();
    if (kind == 7) begin
      n = $urandom_range(1, text_q.size());
      while (text_q.size() > n) void'(text_q.pop_back());
    end
    if ($urandom_range(0, 7) == 0) text_q.push_back(pick_blank());
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    // leading paren, field extremes as operands, >=
    send_char(CH_LPAR, 1'b0);
    send_char(16'h0000, 1'b0);
    send_text(">=", 1'b0);
    send_char(16'hFFFF, 1'b0);
    send_text(")", 1'b1);
    // leading bang and !=
    send_text("!c!=d", 1'b1);
    send_text("e<=f ||g", 1'b1);
    // trailing blank on the last transfer gives a verdict only
    send_text("h==i&&j", 1'b0);
    send_char(16'h3000, 1'b1);
    // lone trailing bang
    send_text("!", 1'b1);
    // error at the first character, nothing until the verdict
    send_text(")x", 1'b1);
  endtask

  task automatic test_random_texts(input int snd_pct, input int rcv_pct, input int n_items);
    int sent;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      build_text();
      for (int i = 0; i < text_q.size(); i++) begin
        send_char(text_q[i], i == text_q.size() - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    drain_results();
    test_random_texts(17, 72, 380);
    drain_results();
    test_random_texts(72, 17, 380);
    drain_results();
    test_random_texts(0, 0, 390);
    drain_results();
    repeat (10) @(negedge clk);
    if (expected_chars.size() != 0) begin
      $error("%0d expected results never transferred", expected_chars.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
